FILE: rtl/rc_channel_map_and_scale_top_assert.svh
// Assertion macros used by the top level of the receiver channel mapper.
`ifndef RC_CHANNEL_MAP_AND_SCALE_TOP_ASSERT_SVH
`define RC_CHANNEL_MAP_AND_SCALE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rcms_pkg.sv
// Package with types, constants and codes of the receiver channel mapper.
package rcms_pkg;

  localparam int NUM_FUNCS      = 4;
  localparam int FUNCTION_COUNT = 4;
  localparam int FRAME_SLOTS    = 16;
  localparam int FUNC_W         = 2;
  localparam int SLOT_W         = 5;
  localparam int REG_IDX_W      = 3;
  localparam int WR_DATA_W      = 39;
  localparam int QUO_W          = 32;
  localparam int DVS_W          = 16;
  localparam int CNT_W          = $clog2(QUO_W + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOCFG = 2'd1;
  localparam logic [1:0] ST_NOCAL = 2'd2;
  localparam logic [1:0] ST_FLAT  = 2'd3;

  typedef struct packed {
    logic [15:0] slot_value;
    logic        end_of_frame;
  } slot_item_t;

  typedef struct packed {
    logic [1:0]         function_id;
    logic [15:0]        raw_reading;
    logic signed [15:0] scaled_value;
    logic [1:0]         status;
    logic               last_result;
  } result_item_t;

  typedef struct packed {
    logic [15:0]       max_duty;
    logic [15:0]       min_duty;
    logic              calibrated;
    logic              configured;
    logic [SLOT_W-1:0] slot;
  } setup_t;

  typedef struct packed {
    logic signed [15:0] span_max;
    logic signed [15:0] span_min;
  } span_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              take;
    logic              load_ops;
    logic              div_start;
    logic              emit;
    logic [FUNC_W-1:0] func;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/rcms_div.sv
// Restoring divider that yields one quotient bit per cycle.
module rcms_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rcms_pkg::QUO_W-1:0] dividend,
  input  logic [rcms_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic [rcms_pkg::QUO_W-1:0] quotient
);
  import rcms_pkg::*;

  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] rem_next;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] quo_next;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem, quo[QUO_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_next = {quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(QUO_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign busy     = count != '0;
  assign quotient = quo;

endmodule

FILE: rtl/rcms_dp.sv
// Datapath: registers, raw store, multiplier, divider, clamp and result register.
module rcms_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rcms_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [rcms_pkg::WR_DATA_W-1:0] wr_data,
  input  rcms_pkg::slot_item_t           slot,
  input  rcms_pkg::ctrl_cmd_t            cmd,
  output rcms_pkg::dp_status_t           status,
  output logic                           result_valid,
  input  logic                           result_stall,
  output rcms_pkg::result_item_t         result
);
  import rcms_pkg::*;

  setup_t            setup_reg [NUM_FUNCS];
  span_t             span_reg  [NUM_FUNCS];
  logic [15:0]       raw_store [NUM_FUNCS];
  logic [SLOT_W-1:0] slot_position;
  logic              in_frame;
  logic [NUM_FUNCS-1:0] match;

  setup_t             sel_setup;
  span_t              sel_span;
  logic signed [16:0] diff_v;
  logic signed [16:0] diff_raw;
  logic signed [16:0] diff_duty;

  logic signed [33:0] prod;
  logic signed [16:0] dd;
  logic [1:0]         code;
  logic [15:0]        raw_sel;
  logic signed [15:0] min_v;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic               neg;

  logic [33:0]        prod_mag;
  logic [16:0]        dd_mag;
  logic               div_busy;
  logic [QUO_W-1:0]   quotient;

  logic signed [33:0] q_s;
  logic signed [34:0] v;
  logic signed [15:0] clamped;
  logic               out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NUM_FUNCS; f++) begin
        setup_reg[f] <= '0;
        span_reg[f]  <= '0;
      end
    end else if (wr_en) begin
      if (!wr_index[0]) begin
        setup_reg[wr_index[REG_IDX_W-1:1]] <= setup_t'(wr_data);
      end else begin
        span_reg[wr_index[REG_IDX_W-1:1]] <= span_t'(wr_data[31:0]);
      end
    end
  end

  // Slot latching into the raw store.
  always_comb begin
    in_frame = {1'b0, slot_position} < (SLOT_W + 1)'(FRAME_SLOTS);
    for (int f = 0; f < NUM_FUNCS; f++) begin
      match[f] = in_frame && (setup_reg[f].slot == slot_position);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_position <= '0;
      for (int f = 0; f < NUM_FUNCS; f++) begin
        raw_store[f] <= '0;
      end
    end else if (cmd.take) begin
      for (int f = 0; f < NUM_FUNCS; f++) begin
        if (match[f]) begin
          raw_store[f] <= slot.slot_value;
        end else if (slot_position == '0) begin
          raw_store[f] <= '0;
        end
      end
      if (slot.end_of_frame) begin
        slot_position <= '0;
      end else if (slot_position != '1) begin
        slot_position <= slot_position + 1'b1;
      end
    end
  end

  // Operand preparation and the product.
  always_comb begin
    sel_setup = setup_reg[cmd.func];
    sel_span  = span_reg[cmd.func];
    diff_v    = {sel_span.span_max[15], sel_span.span_max}
              - {sel_span.span_min[15], sel_span.span_min};
    diff_raw  = $signed({1'b0, raw_store[cmd.func]}) - $signed({1'b0, sel_setup.min_duty});
    diff_duty = $signed({1'b0, sel_setup.max_duty}) - $signed({1'b0, sel_setup.min_duty});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ops) begin
      prod  <= diff_v * diff_raw;
      dd    <= diff_duty;
      min_v <= sel_span.span_min;
      if (sel_span.span_min <= sel_span.span_max) begin
        lo <= sel_span.span_min;
        hi <= sel_span.span_max;
      end else begin
        lo <= sel_span.span_max;
        hi <= sel_span.span_min;
      end
      raw_sel <= sel_setup.configured ? raw_store[cmd.func] : 16'd0;
      if (!sel_setup.configured) begin
        code <= ST_NOCFG;
      end else if (!sel_setup.calibrated) begin
        code <= ST_NOCAL;
      end else if (sel_setup.max_duty == sel_setup.min_duty) begin
        code <= ST_FLAT;
      end else begin
        code <= ST_OK;
      end
    end
    if (cmd.div_start) begin
      neg <= prod[33] ^ dd[16];
    end
  end

  assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);
  assign dd_mag   = dd[16] ? 17'(-dd) : 17'(dd);

  rcms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag[QUO_W-1:0]),
    .divisor  (dd_mag[DVS_W-1:0]),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Sign restore, offset and clamp.
  always_comb begin
    q_s = neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    v   = $signed({{19{min_v[15]}}, min_v}) + $signed({q_s[33], q_s});
    if (v > $signed({{19{hi[15]}}, hi})) begin
      clamped = hi;
    end else if (v < $signed({{19{lo[15]}}, lo})) begin
      clamped = lo;
    end else begin
      clamped = v[15:0];
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.function_id  <= cmd.func;
      result.raw_reading  <= raw_sel;
      result.scaled_value <= (code == ST_OK) ? clamped : 16'sd0;
      result.status       <= code;
      result.last_result  <= cmd.func == FUNC_W'(FUNCTION_COUNT - 1);
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = out_free;

endmodule

FILE: rtl/rcms_ctrl.sv
// Controller state machine that sequences slot intake and the per-channel conversions.
module rcms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 slot_valid,
  input  logic                 end_of_frame,
  output logic                 slot_stall,
  input  rcms_pkg::dp_status_t status,
  output rcms_pkg::ctrl_cmd_t  cmd
);
  import rcms_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [FUNC_W-1:0] func;
  logic [FUNC_W-1:0] func_next;
  logic              last_func;

  assign last_func = func == FUNC_W'(FUNCTION_COUNT - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      func  <= '0;
    end else begin
      state <= state_next;
      func  <= func_next;
    end
  end

  always_comb begin
    state_next = state;
    func_next  = func;
    unique case (state)
      S_IDLE: begin
        if (slot_valid && end_of_frame) begin
          state_next = S_LOAD;
          func_next  = '0;
        end
      end
      S_LOAD: begin
        state_next = S_START;
      end
      S_START: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          if (last_func) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_LOAD;
            func_next  = func + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.take      = 1'b0;
    cmd.load_ops  = 1'b0;
    cmd.div_start = 1'b0;
    cmd.emit      = 1'b0;
    cmd.func      = func;
    slot_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        slot_stall = 1'b0;
        cmd.take   = slot_valid;
      end
      S_LOAD: begin
        cmd.load_ops = 1'b1;
      end
      S_START: begin
        cmd.div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/rc_channel_map_and_scale_top.sv
// Top level of the receiver channel mapper with linear calibration and clamp.
// An ordinary slot request is taken while the controller is idle. A slot request
// that ends a frame starts one conversion per function channel; each has a step
// for operand load and multiply, one for divider start, a wait while the shared
// restoring divider runs its 32 steps and is seen idle, and a step for the clamp
// into the result register. Such a slot keeps the input side stalled through all
// of these conversions, also while the result side stalls. No slot is taken until
// the last result of the frame has been loaded into the result register.
`include "rc_channel_map_and_scale_top_assert.svh"

module rc_channel_map_and_scale_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rcms_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [rcms_pkg::WR_DATA_W-1:0] wr_data,
  input  logic                           slot_valid,
  output logic                           slot_stall,
  input  rcms_pkg::slot_item_t           slot,
  output logic                           result_valid,
  input  logic                           result_stall,
  output rcms_pkg::result_item_t         result
);
  import rcms_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  rcms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .slot_valid   (slot_valid),
    .end_of_frame (slot.end_of_frame),
    .slot_stall   (slot_stall),
    .status       (dp_status),
    .cmd          (cmd)
  );

  rcms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .slot         (slot),
    .cmd          (cmd),
    .status       (dp_status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `RCMS_ASSERT_NEXT(a_eof_holds_input, slot_valid && !slot_stall && slot.end_of_frame, slot_stall, "End of frame did not stall the input.")
  `RCMS_ASSERT_NEXT(a_div_starts, cmd.div_start, dp_status.div_busy, "Divider failed to start.")
  `RCMS_ASSERT_NEXT(a_emit_shows, cmd.emit, result_valid, "Emitted result not presented.")
  `RCMS_ASSERT_NOW(a_bad_status_zero, result_valid && result.status != ST_OK, result.scaled_value == 16'sd0, "Nonzero status with nonzero value.")

endmodule
